// ===== rtl/dsa_pkg.sv =====
// ----------------------------------------------------------------------------
// DSA engine package
// Shared types and constants for the DSA sign/verify engine.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned CMD_W = 1;
  localparam logic CMD_SIGN   = 1'b0;
  localparam logic CMD_VERIFY = 1'b1;

  localparam logic [2:0] REG_P = 3'd0;
  localparam logic [2:0] REG_Q = 3'd1;
  localparam logic [2:0] REG_G = 3'd2;
  localparam logic [2:0] REG_X = 3'd3;
  localparam logic [2:0] REG_Y = 3'd4;

  // Arithmetic unit operations
  typedef enum logic [1:0] {
    OP_RED,   // a mod m, restoring bit-serial
    OP_MUL,   // a*b mod m, double-and-add over b bits
    OP_DIV    // a / b and a mod b, restoring
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED_H,      // h = hash mod q
    S_POW_INIT,   // res = 1 mod p, e = exponent
    S_POW_BASE,
    S_POW_MUL,
    S_POW_SQR,
    S_POW_DONE,
    S_INV_INIT,   // r1 = a mod q
    S_INV_DIV,
    S_INV_MUL,
    S_INV_UPD,
    S_INV_DONE,
    S_SIGN_R,     // r = pw mod q
    S_SIGN_XR,
    S_SIGN_S,
    S_VER_U1,
    S_VER_U2,
    S_VER_V,
    S_VER_VQ,
    S_OUT
  } state_t;

endpackage

// ===== rtl/dsa_sign_verify_engine.sv =====
// ----------------------------------------------------------------------------
// DSA sign/verify engine
// Signs a hash with nonce k or checks a signature pair against configured keys.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------
//  input   | in_command, in_message_hash, in_nonce_k,| in_valid / in_ready
//          | in_sig_r_in, in_sig_s_in                |
//  result  | out_sig_r_out, out_sig_s_out,           | out_valid / out_ready
//          | out_sig_valid, out_status               |
//  config  | cfg_psel .. cfg_pready (APB)            | write on access phase
//
// One item at a time. Every reduce, multiply and divide runs through one
// shared serial unit at one bit per cycle. A sign is one exponentiation
// (up to 2*WIDTH multiplies) plus one Euclidean inverse (up to ~1.5*WIDTH
// divide+multiply rounds); verify runs two exponentiations plus the inverse.
// Reset (rst_n low, synchronous) loads the register defaults and idles.
// A finished item sits in the output register until taken; in_ready stays
// low until then.
module dsa_sign_verify_engine import dsa_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_command,
  input  logic [31:0]      in_message_hash,
  input  logic [31:0]      in_nonce_k,
  input  logic [31:0]      in_sig_r_in,
  input  logic [31:0]      in_sig_s_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_sig_r_out,
  output logic [31:0]      out_sig_s_out,
  output logic             out_sig_valid,
  output logic             out_status,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [4:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned CW = $clog2(WIDTH + 1);
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  // configuration registers
  logic [WIDTH-1:0] p_r, q_r, g_r, x_r, y_r;
  logic [2:0] widx;
  assign widx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= WIDTH'(23);
      q_r <= WIDTH'(11);
      g_r <= WIDTH'(4);
      x_r <= WIDTH'(3);
      y_r <= WIDTH'(18);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (widx)
        REG_P: p_r <= WIDTH'(cfg_pwdata);
        REG_Q: q_r <= WIDTH'(cfg_pwdata);
        REG_G: g_r <= WIDTH'(cfg_pwdata);
        REG_X: x_r <= WIDTH'(cfg_pwdata);
        REG_Y: y_r <= WIDTH'(cfg_pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_P: cfg_prdata = 32'(p_r);
      REG_Q: cfg_prdata = 32'(q_r);
      REG_G: cfg_prdata = 32'(g_r);
      REG_X: cfg_prdata = 32'(x_r);
      REG_Y: cfg_prdata = 32'(y_r);
      default: cfg_prdata = '0;
    endcase
  end

  // shared serial unit
  logic             alu_start;
  alu_op_t          alu_op;
  logic [WIDTH-1:0] alu_a, alu_b, alu_m, alu_res, alu_rem;
  logic             alu_done;

  dsa_alu #(.WIDTH(WIDTH)) u_alu (
    .clk(clk), .rst_n(rst_n), .start(alu_start), .op(alu_op),
    .a(alu_a), .b(alu_b), .m(alu_m),
    .done(alu_done), .res(alu_res), .rem(alu_rem)
  );

  // datapath registers
  state_t st_r, st_nxt;
  logic             started_r, started_nxt;   // ALU launched in this state
  logic             cmd_r;
  logic [WIDTH-1:0] hash_r, k_r, rin_r, sin_r;
  logic [WIDTH-1:0] h_r, h_nxt;
  // exponentiation
  logic [WIDTH-1:0] pres_r, pres_nxt, pb_r, pb_nxt, pe_r, pe_nxt;
  logic [WIDTH-1:0] pbase_r, pbase_nxt, pexp_r, pexp_nxt;
  logic [1:0]       pwho_r, pwho_nxt;          // 0 sign g^k, 1 g^u1, 2 y^u2
  // inverse
  logic [WIDTH-1:0] ia_r, ia_nxt, r0_r, r0_nxt, r1_r, r1_nxt;
  logic [WIDTH-1:0] t0_r, t0_nxt, t1_r, t1_nxt, qt_r, qt_nxt;
  logic             iok_r, iok_nxt;
  logic [WIDTH-1:0] inv_r, inv_nxt;
  // results
  logic [WIDTH-1:0] rr_r, rr_nxt, tt_r, tt_nxt, u2_r, u2_nxt, v1_r, v1_nxt;
  logic [WIDTH-1:0] osr_r, osr_nxt, oss_r, oss_nxt;
  logic             ovld_r, ovld_nxt, osts_r, osts_nxt, out_valid_r, out_valid_nxt;

  logic in_acc;
  assign in_acc = in_valid && in_ready;
  assign in_ready = (st_r == S_IDLE) && !out_valid_r;

  // t0 - prod mod q
  logic [WIDTH-1:0] tsub;
  assign tsub = (t0_r >= alu_res) ? t0_r - alu_res : t0_r + (q_r - alu_res);
  // h + x r mod q, both below q
  logic [WIDTH-1:0] hadd;
  assign hadd = (h_r >= q_r - alu_res) ? h_r - (q_r - alu_res) : h_r + alu_res;
  logic rs_ok;
  assign rs_ok = (rin_r != '0) && (rin_r < q_r) && (sin_r != '0) && (sin_r < q_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:     if (in_acc) st_nxt = S_RED_H;
      S_RED_H:    if (alu_done) st_nxt = (cmd_r == CMD_SIGN) ? S_POW_INIT : S_INV_INIT;
      S_POW_INIT: st_nxt = (p_r == '0) ? S_POW_DONE : S_POW_BASE;
      S_POW_BASE: if (alu_done) st_nxt = S_POW_MUL;
      S_POW_MUL: begin
        if (pe_r == '0) st_nxt = S_POW_DONE;
        else if (!pe_r[0] || alu_done) st_nxt = S_POW_SQR;
      end
      S_POW_SQR:  if (alu_done) st_nxt = S_POW_MUL;
      S_POW_DONE: begin
        unique case (pwho_r)
          2'd0: st_nxt = S_SIGN_R;
          2'd1: st_nxt = S_POW_INIT;
          default: st_nxt = S_VER_V;
        endcase
      end
      S_INV_INIT: begin
        if (q_r < WIDTH'(2)) st_nxt = S_INV_DONE;
        else if (alu_done) st_nxt = S_INV_DIV;
      end
      S_INV_DIV: begin
        if (r1_r == '0) st_nxt = S_INV_DONE;
        else if (alu_done) st_nxt = S_INV_MUL;
      end
      S_INV_MUL:  if (alu_done) st_nxt = S_INV_DIV;
      S_INV_DONE: begin
        if (cmd_r == CMD_SIGN) st_nxt = S_SIGN_XR;
        else if (iok_nxt && rs_ok) st_nxt = S_VER_U1;
        else st_nxt = S_OUT;
      end
      S_SIGN_R:   if (alu_done) st_nxt = S_INV_INIT;
      S_SIGN_XR:  if (!iok_r) st_nxt = S_OUT; else if (alu_done) st_nxt = S_SIGN_S;
      S_SIGN_S:   if (alu_done) st_nxt = S_OUT;
      S_VER_U1:   if (alu_done) st_nxt = S_VER_U2;
      S_VER_U2:   if (alu_done) st_nxt = S_POW_INIT;
      S_VER_V:    if (alu_done) st_nxt = S_VER_VQ;
      S_VER_VQ:   if (alu_done) st_nxt = S_OUT;
      S_OUT:      st_nxt = S_IDLE;
      default:    st_nxt = S_IDLE;
    endcase
  end

  // datapath and ALU control
  always_comb begin
    started_nxt = started_r;
    alu_start = 1'b0;
    alu_op = OP_RED;
    alu_a = '0;
    alu_b = '0;
    alu_m = q_r;
    h_nxt = h_r;
    pres_nxt = pres_r; pb_nxt = pb_r; pe_nxt = pe_r;
    pbase_nxt = pbase_r; pexp_nxt = pexp_r; pwho_nxt = pwho_r;
    ia_nxt = ia_r; r0_nxt = r0_r; r1_nxt = r1_r;
    t0_nxt = t0_r; t1_nxt = t1_r; qt_nxt = qt_r;
    iok_nxt = iok_r; inv_nxt = inv_r;
    rr_nxt = rr_r; tt_nxt = tt_r; u2_nxt = u2_r; v1_nxt = v1_r;
    osr_nxt = osr_r; oss_nxt = oss_r; ovld_nxt = ovld_r; osts_nxt = osts_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        started_nxt = 1'b0;
        pwho_nxt = 2'd0;
        // result fields hold while a finished item waits; clear on the next one
        if (in_acc) begin
          rr_nxt = '0; oss_nxt = '0; ovld_nxt = 1'b0; osts_nxt = 1'b0;
        end
      end
      S_RED_H: begin
        alu_op = OP_RED; alu_a = hash_r; alu_m = q_r;
        alu_start = !started_r;
        started_nxt = 1'b1;
        if (alu_done) begin
          h_nxt = alu_res;
          started_nxt = 1'b0;
          pbase_nxt = g_r;
          pexp_nxt = k_r;
          ia_nxt = (cmd_r == CMD_SIGN) ? k_r : sin_r;
        end
      end
      S_POW_INIT: begin
        pres_nxt = (p_r == ONE) ? '0 : ONE;
        pe_nxt = pexp_r;
        started_nxt = 1'b0;
        if (p_r == '0) pres_nxt = '0;
      end
      S_POW_BASE: begin
        alu_op = OP_RED; alu_a = pbase_r; alu_m = p_r;
        alu_start = !started_r; started_nxt = 1'b1;
        if (alu_done) begin pb_nxt = alu_res; started_nxt = 1'b0; end
      end
      S_POW_MUL: begin
        alu_op = OP_MUL; alu_a = pb_r; alu_b = pres_r; alu_m = p_r;
        if (pe_r != '0 && pe_r[0]) begin
          alu_start = !started_r; started_nxt = 1'b1;
          if (alu_done) begin pres_nxt = alu_res; started_nxt = 1'b0; end
        end
      end
      S_POW_SQR: begin
        alu_op = OP_MUL; alu_a = pb_r; alu_b = pb_r; alu_m = p_r;
        alu_start = !started_r; started_nxt = 1'b1;
        if (alu_done) begin
          pb_nxt = alu_res; started_nxt = 1'b0;
          pe_nxt = {1'b0, pe_r[WIDTH-1:1]};
        end
      end
      S_POW_DONE: begin
        unique case (pwho_r)
          2'd0: ;
          2'd1: begin
            v1_nxt = pres_r; pbase_nxt = y_r; pexp_nxt = u2_r; pwho_nxt = 2'd2;
          end
          default: ;
        endcase
      end
      S_SIGN_R: begin
        alu_op = OP_RED; alu_a = pres_r; alu_m = q_r;
        alu_start = !started_r; started_nxt = 1'b1;
        if (alu_done) begin rr_nxt = alu_res; started_nxt = 1'b0; end
      end
      S_INV_INIT: begin
        alu_op = OP_RED; alu_a = ia_r; alu_m = q_r;
        iok_nxt = 1'b0; inv_nxt = '0;
        t0_nxt = '0; t1_nxt = ONE; r0_nxt = q_r;
        if (q_r >= WIDTH'(2)) begin
          alu_start = !started_r; started_nxt = 1'b1;
          if (alu_done) begin r1_nxt = alu_res; started_nxt = 1'b0; end
        end
      end
      S_INV_DIV: begin
        alu_op = OP_DIV; alu_a = r0_r; alu_b = r1_r;
        if (r1_r != '0) begin
          alu_start = !started_r; started_nxt = 1'b1;
          if (alu_done) begin
            qt_nxt = alu_res; started_nxt = 1'b0;
            r0_nxt = r1_r; r1_nxt = alu_rem;
          end
        end
      end
      S_INV_MUL: begin
        // qt < q except possibly in the first round; it goes in as the scanned b
        // operand, whose bits need no reduction, while the added operand t1 < q.
        alu_op = OP_MUL; alu_a = t1_r; alu_b = qt_r; alu_m = q_r;
        alu_start = !started_r; started_nxt = 1'b1;
        if (alu_done) begin
          started_nxt = 1'b0;
          t0_nxt = t1_r; t1_nxt = tsub;
        end
      end
      S_INV_DONE: begin
        started_nxt = 1'b0;
        if (q_r >= WIDTH'(2) && r0_r == ONE) begin
          iok_nxt = 1'b1; inv_nxt = t0_r;
        end else begin
          iok_nxt = 1'b0;
        end
        if (cmd_r == CMD_SIGN) osts_nxt = !iok_nxt;
        else osts_nxt = !iok_nxt;
      end
      S_SIGN_XR: begin
        alu_op = OP_MUL; alu_a = rr_r; alu_b = x_r; alu_m = q_r;
        if (iok_r) begin
          alu_start = !started_r; started_nxt = 1'b1;
          if (alu_done) begin tt_nxt = hadd; started_nxt = 1'b0; end
        end
      end
      S_SIGN_S: begin
        alu_op = OP_MUL; alu_a = inv_r; alu_b = tt_r; alu_m = q_r;
        alu_start = !started_r; started_nxt = 1'b1;
        if (alu_done) begin oss_nxt = alu_res; started_nxt = 1'b0; end
      end
      S_VER_U1: begin
        alu_op = OP_MUL; alu_a = inv_r; alu_b = h_r; alu_m = q_r;
        alu_start = !started_r; started_nxt = 1'b1;
        if (alu_done) begin
          pexp_nxt = alu_res; pbase_nxt = g_r; pwho_nxt = 2'd1;
          started_nxt = 1'b0;
        end
      end
      S_VER_U2: begin
        alu_op = OP_MUL; alu_a = inv_r; alu_b = rin_r; alu_m = q_r;
        alu_start = !started_r; started_nxt = 1'b1;
        if (alu_done) begin u2_nxt = alu_res; started_nxt = 1'b0; end
      end
      S_VER_V: begin
        alu_op = OP_MUL; alu_a = v1_r; alu_b = pres_r; alu_m = p_r;
        alu_start = !started_r; started_nxt = 1'b1;
        if (alu_done) begin tt_nxt = alu_res; started_nxt = 1'b0; end
      end
      S_VER_VQ: begin
        alu_op = OP_RED; alu_a = tt_r; alu_m = q_r;
        alu_start = !started_r; started_nxt = 1'b1;
        if (alu_done) begin ovld_nxt = (alu_res == rin_r); started_nxt = 1'b0; end
      end
      S_OUT: begin
        osr_nxt = rr_r;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      started_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      started_r <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      cmd_r <= in_command;
      hash_r <= WIDTH'(in_message_hash);
      k_r <= WIDTH'(in_nonce_k);
      rin_r <= WIDTH'(in_sig_r_in);
      sin_r <= WIDTH'(in_sig_s_in);
    end
    h_r <= h_nxt;
    pres_r <= pres_nxt; pb_r <= pb_nxt; pe_r <= pe_nxt;
    pbase_r <= pbase_nxt; pexp_r <= pexp_nxt; pwho_r <= pwho_nxt;
    ia_r <= ia_nxt; r0_r <= r0_nxt; r1_r <= r1_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; qt_r <= qt_nxt;
    iok_r <= iok_nxt; inv_r <= inv_nxt;
    rr_r <= rr_nxt; tt_r <= tt_nxt; u2_r <= u2_nxt; v1_r <= v1_nxt;
    osr_r <= osr_nxt; oss_r <= oss_nxt; ovld_r <= ovld_nxt; osts_r <= osts_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_sig_r_out = 32'(osr_r);
  assign out_sig_s_out = 32'(oss_r);
  assign out_sig_valid = ovld_r;
  assign out_status    = osts_r;

endmodule

// ===== rtl/dsa_alu.sv =====
// ----------------------------------------------------------------------------
// DSA serial arithmetic unit
// One bit per cycle modular reduce, modular multiply and integer divide.
// ----------------------------------------------------------------------------
module dsa_alu import dsa_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  alu_op_t          op,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] res,     // mod result or quotient
  output logic [WIDTH-1:0] rem
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  alu_op_t          op_r, op_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] sh_r, sh_nxt;    // bits fed MSB first
  logic [WIDTH-1:0] acc_r, acc_nxt;  // partial remainder / accumulator
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] ad_r, ad_nxt;    // addend for multiply, zero otherwise
  logic [WIDTH-1:0] m_r, m_nxt;

  // acc2 = 2*acc + bit (WIDTH+1 bits), reduce by one compare-subtract
  logic [WIDTH:0]   dbl, dsub, sum, ssub;
  logic [WIDTH-1:0] dred;
  logic             dge;

  always_comb begin
    dbl = {acc_r, (op_r == OP_MUL) ? 1'b0 : sh_r[WIDTH-1]};
    dge = (dbl >= {1'b0, m_r});
    dsub = dbl - {1'b0, m_r};
    dred = dge ? dsub[WIDTH-1:0] : dbl[WIDTH-1:0];
    sum  = {1'b0, dred} + {1'b0, ad_r};
    ssub = sum - {1'b0, m_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    sh_nxt = sh_r;
    acc_nxt = acc_r;
    q_nxt = q_r;
    ad_nxt = ad_r;
    m_nxt = m_r;
    if (start) begin
      busy_nxt = 1'b1;
      op_nxt = op;
      cnt_nxt = CW'(WIDTH);
      acc_nxt = '0;
      q_nxt = '0;
      unique case (op)
        OP_MUL: begin
          // a reduced first by caller; b bits scanned
          sh_nxt = b;
          ad_nxt = a;
          m_nxt = m;
        end
        OP_DIV: begin
          sh_nxt = a;
          ad_nxt = '0;
          m_nxt = b;
        end
        default: begin
          sh_nxt = a;
          ad_nxt = '0;
          m_nxt = m;
        end
      endcase
    end else if (busy_r) begin
      sh_nxt = {sh_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (op_r == OP_MUL) begin
        if (sh_r[WIDTH-1] && (sum >= {1'b0, m_r})) acc_nxt = ssub[WIDTH-1:0];
        else if (sh_r[WIDTH-1]) acc_nxt = sum[WIDTH-1:0];
        else acc_nxt = dred;
      end else begin
        acc_nxt = dred;
        q_nxt = {q_r[WIDTH-2:0], dge};
      end
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r <= op_nxt;
    cnt_r <= cnt_nxt;
    sh_r <= sh_nxt;
    acc_r <= acc_nxt;
    q_r <= q_nxt;
    ad_r <= ad_nxt;
    m_r <= m_nxt;
  end

  // zero modulus gives zero for reduce and multiply
  assign done = done_r;
  assign res  = (op_r == OP_DIV) ? q_r : ((m_r == '0) ? '0 : acc_r);
  assign rem  = acc_r;

endmodule

// ===== bench/dsa_checker.sv =====
// ----------------------------------------------------------------------------
// DSA engine result checker
// Watches both item channels, predicts each result from the register shadow
// and compares the accepted results field by field, oldest first.
// ----------------------------------------------------------------------------
module dsa_checker import dsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_message_hash,
  input  logic [31:0] in_nonce_k,
  input  logic [31:0] in_sig_r_in,
  input  logic [31:0] in_sig_s_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_sig_r_out,
  input  logic [31:0] out_sig_s_out,
  input  logic        out_sig_valid,
  input  logic        out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] s;
    logic        ok;
    logic        st;
  } dsa_result_t;

  dsa_result_t signature_q[$];
  logic [31:0] p_q, q_q, g_q, x_q, y_q;

  assign pending = signature_q.size();

  function automatic logic [63:0] modred(logic [63:0] v, logic [63:0] m);
    return (m == 0) ? 64'd0 : v % m;
  endfunction

  // a*b mod m; operands fit 32 bits so a 64-bit product is exact
  function automatic logic [63:0] modmul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    if (m == 0) return 0;
    return (modred(a, m) * modred(b, m)) % m;
  endfunction

  function automatic logic [63:0] modexp(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    if (m == 0) return 0;
    acc = modred(1, m);
    b = modred(b, m);
    while (e != 0) begin
      if (e[0]) acc = modmul(acc, b, m);
      b = modmul(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // extended Euclid; returns 1 and the inverse when gcd is one
  function automatic logic modinv(logic [63:0] a, logic [63:0] m, output logic [63:0] inv);
    logic [63:0] r0, r1, t0, t1, qt, tmp, pr;
    inv = 0;
    if (m < 2) return 0;
    r0 = m; r1 = a % m; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      tmp = r0 - qt * r1;
      r0 = r1; r1 = tmp;
      pr = modmul(qt, t1, m);
      tmp = (t0 >= pr) ? t0 - pr : t0 + (m - pr);
      t0 = t1; t1 = tmp;
    end
    if (r0 != 1) return 0;
    inv = t0;
    return 1;
  endfunction

  function automatic dsa_result_t predict_signature(logic cmd, logic [31:0] hash,
      logic [31:0] k, logic [31:0] rin, logic [31:0] sin);
    dsa_result_t res;
    logic [63:0] h, inv, t, u1, u2, v;
    res = '0;
    h = modred(64'(hash), 64'(q_q));
    if (cmd == CMD_SIGN) begin
      res.r = 32'(modred(modexp(64'(g_q), 64'(k), 64'(p_q)), 64'(q_q)));
      if (modinv(64'(k), 64'(q_q), inv)) begin
        t = (h + modmul(64'(x_q), 64'(res.r), 64'(q_q))) % 64'(q_q);
        res.s = 32'(modmul(inv, t, 64'(q_q)));
      end else res.st = 1'b1;
    end else begin
      if (!modinv(64'(sin), 64'(q_q), inv)) res.st = 1'b1;
      else if (rin != 0 && rin < q_q && sin != 0 && sin < q_q) begin
        u1 = modmul(h, inv, 64'(q_q));
        u2 = modmul(64'(rin), inv, 64'(q_q));
        v = modmul(modexp(64'(g_q), u1, 64'(p_q)), modexp(64'(y_q), u2, 64'(p_q)),
                   64'(p_q));
        res.ok = (modred(v, 64'(q_q)) == 64'(rin));
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    dsa_result_t got, want;
    if (!rst_n) begin
      p_q <= 23; q_q <= 11; g_q <= 4; x_q <= 3; y_q <= 18;
      fail_count <= 0;
      results_seen <= 0;
      signature_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_P: p_q <= cfg_pwdata;
          REG_Q: q_q <= cfg_pwdata;
          REG_G: g_q <= cfg_pwdata;
          REG_X: x_q <= cfg_pwdata;
          REG_Y: y_q <= cfg_pwdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        signature_q.push_back(predict_signature(in_command, in_message_hash,
                                                in_nonce_k, in_sig_r_in, in_sig_s_in));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        got = '{out_sig_r_out, out_sig_s_out, out_sig_valid, out_status};
        if (signature_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("ERROR: unexpected result %h", got);
        end else begin
          want = signature_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("ERROR: r %h/%h s %h/%h valid %b/%b status %b/%b (exp/act)",
                       want.r, got.r, want.s, got.s, want.ok, got.ok, want.st, got.st);
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// DSA engine testbench
// Drives sign and verify items over several key sets and idling phases;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench import dsa_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0, in_ready;
  logic        in_command = 1'b0;
  logic [31:0] in_message_hash = '0, in_nonce_k = '0, in_sig_r_in = '0, in_sig_s_in = '0;
  logic        out_valid, out_ready = 1'b0;
  logic [31:0] out_sig_r_out, out_sig_s_out;
  logic        out_sig_valid, out_status;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending, results_seen;
  int          send_idle_pct = 0, stall_pct = 0;
  int          n_sign = 0, n_verify = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dsa_sign_verify_engine #(.WIDTH(32)) dut (.*);

  dsa_checker u_checker (.*);

  // receiver stalls at random, by phase
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Key sets {p,q,g,x,y}: sets 0-1 safe primes p = 2q+1, g of order q; 2 large, 3 degenerate.
  // Pairs taken for realistic verify items come from signing with the key.
  logic [31:0] keyset [4][5] = '{
    '{32'd23, 32'd11, 32'd4, 32'd3, 32'd18},
    '{32'd2039, 32'd1019, 32'd4, 32'd77, 32'd0},
    '{32'd4294967291, 32'd4294967279, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd2},
    '{32'd1, 32'd0, 32'd0, 32'd0, 32'd0}
  };

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // power by repeated squaring, used only to derive the public key y
  function automatic logic [31:0] key_exp(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = acc * b % m;
      b = b * b % m;
      e >>= 1;
    end
    return 32'(acc);
  endfunction

  task automatic load_keys(int set);
    logic [31:0] y;
    y = keyset[set][4];
    if (set == 1) y = key_exp(keyset[1][2], keyset[1][3], keyset[1][0]);
    reg_write(REG_P, keyset[set][0]);
    reg_write(REG_Q, keyset[set][1]);
    reg_write(REG_G, keyset[set][2]);
    reg_write(REG_X, keyset[set][3]);
    reg_write(REG_Y, y);
  endtask

  task automatic send_item(logic cmd, logic [31:0] h, logic [31:0] k,
                           logic [31:0] r, logic [31:0] s);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1; in_command <= cmd; in_message_hash <= h;
    in_nonce_k <= k; in_sig_r_in <= r; in_sig_s_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    if (cmd == CMD_SIGN) n_sign++; else n_verify++;
    // the engine takes one item at a time, so a gap before the next item costs nothing
    @(posedge clk);
  endtask

  // wait until the engine is drained, plus slack before touching registers
  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_item(logic [31:0] q);
    logic [31:0] r, s, h;
    int kind;
    kind = $urandom_range(9);
    h = $urandom;
    r = (q > 1) ? $urandom_range(q - 1, 1) : $urandom;
    s = (q > 1) ? $urandom_range(q - 1, 1) : $urandom;
    case (kind)
      0, 1, 2, 3: send_item(CMD_SIGN, h, $urandom, $urandom, $urandom);
      4:          send_item(CMD_SIGN, h, (q > 1) ? $urandom_range(q - 1) : 0, 0, 0);
      5, 6, 7:    send_item(CMD_VERIFY, h, $urandom, r, s);
      8:          send_item(CMD_VERIFY, h, $urandom, $urandom, $urandom);
      default:    send_item(CMD_VERIFY, $urandom, 0, (q < 3) ? q : r + q, $urandom_range(1) ? q : 0);
    endcase
  endtask

  // sign then verify the same hash, so valid signatures are exercised
  task automatic sign_then_verify(logic [31:0] h, logic [31:0] k);
    send_item(CMD_SIGN, h, k, 0, 0);
    while (!(out_valid && out_ready)) @(posedge clk);
    send_item(CMD_VERIFY, h, $urandom, out_sig_r_out, out_sig_s_out);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset keys, field extremes, both commands, corner cases
    send_item(CMD_SIGN, 32'd0, 32'd0, 0, 0);                 // zero exponent
    send_item(CMD_SIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_SIGN, 32'd5, 32'd11, 0, 0);               // k = q, no inverse
    send_item(CMD_SIGN, 32'd7, 32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_VERIFY, 32'd7, 32'd0, 32'd0, 32'd3);       // r zero
    send_item(CMD_VERIFY, 32'd7, 32'hFFFF_FFFF, 32'd11, 32'd3); // r = q
    send_item(CMD_VERIFY, 32'd7, 32'd0, 32'd4, 32'd0);       // s without inverse
    send_item(CMD_VERIFY, 32'd7, 32'd0, 32'd4, 32'd14);      // s above q
    send_item(CMD_VERIFY, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sign_then_verify(32'd9, 32'd3);
    sign_then_verify(32'hAAAA_5555, 32'd7);
    drain();
    load_keys(3);                                            // degenerate moduli
    send_item(CMD_SIGN, 32'd3, 32'd5, 0, 0);
    send_item(CMD_VERIFY, 32'd3, 32'd0, 32'd1, 32'd1);
    drain();
    reg_write(REG_P, 32'd0); reg_write(REG_Q, 32'd1);
    send_item(CMD_SIGN, 32'd3, 32'd5, 0, 0);
    send_item(CMD_VERIFY, 32'd3, 32'd0, 32'd1, 32'd1);
    drain();

    // random phases over key sets and idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      load_keys(ph % 3);
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      for (int i = 0; i < 22; i++) begin
        if ($urandom_range(3) == 0) sign_then_verify($urandom, $urandom);
        else random_item(keyset[ph % 3][1]);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d sign and %0d verify items, %0d results checked, four key sets.",
             n_sign, n_verify, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // generous guard: ~200 items at worst-case compute and stalls
  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
